@@ src/assert_macros.svh @@
// Assertion macros used by the matcher top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, held off during reset.
`define ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication, sampled on clk, held off during reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

@@ src/kmp_pkg.sv @@
// Shared constants, types and helpers of the streaming pattern matcher.
package kmp_pkg;

    localparam int PATTERN_MAX   = 32;
    localparam int POSITION_BITS = 32;
    localparam int BYTE_BITS     = 8;
    localparam int LEN_BITS      = 6;
    localparam int CFG_BITS      = 64;
    localparam int CFG_IDX_BITS  = 3;
    localparam int START_BITS    = 32;
    localparam int BYTES_PER_REG = CFG_BITS / BYTE_BITS;
    localparam int NUM_WORDS     = 4;
    localparam int IDX_BITS      = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int EFF_BITS      = $clog2(PATTERN_MAX + 1);

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_BITS-1:0] REG_LENGTH  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BYTES_0 = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_BYTES_3 = 3'd4;

    // Control handed to every cell of the chain
    typedef struct packed {
        logic advance;
        logic clear;
    } cell_ctrl_t;

    // Clamp the programmed length into 1..PATTERN_MAX
    function automatic logic [EFF_BITS-1:0] eff_len(input logic [LEN_BITS-1:0] len);
        logic [EFF_BITS-1:0] n;
        if (len == '0)
            n = EFF_BITS'(1);
        else if (int'(len) > PATTERN_MAX)
            n = EFF_BITS'(PATTERN_MAX);
        else
            n = EFF_BITS'(len);
        return n;
    endfunction

endpackage

@@ src/kmp_stream_matcher.sv @@
// Top level of the streaming exact-pattern matcher.
// Usage:
//   Program the pattern through the write port: index 0 takes the length
//   (0 acts as 1, values above 32 act as 32), indexes 1 to 4 take eight
//   pattern bytes each, byte k in bits 8k upward. Any accepted write to
//   indexes 0..4 restarts the search; other indexes are dropped.
//   Text bytes enter on the slave stream, one byte per request, with tlast
//   on the final byte of a text. Every byte yields exactly one result
//   request on the master stream: tuser is the match flag, tdata the start
//   position of the occurrence ending at that byte (0 when none).
// Timing:
//   A row of cells, one per pattern byte, holds the set of matched prefixes;
//   each accepted byte shifts that set one cell along the row. A result is
//   registered in the cycle after its byte is accepted, and a new byte is taken
//   every cycle while the output register is empty or being drained.
// Reset and stall:
//   Reset clears the row, the position and the output register and loads a
//   one-byte zero pattern. A stalled receiver holds the result and stops the
//   slave side once the output register is full. After a tlast byte the row
//   and the position return to zero; the position saturates at its maximum.
`include "assert_macros.svh"

module kmp_stream_matcher (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // write port
    input  logic                                  cfg_we,
    input  logic [kmp_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [kmp_pkg::CFG_BITS-1:0]          cfg_data,
    // text stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [7:0]                            s_axis_tdata,   // [7:0] text_byte
    input  logic                                  s_axis_tlast,   // end_of_text
    // result stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [31:0]                           m_axis_tdata,   // [31:0] match_start
    output logic                                  m_axis_tuser    // [0] match_found
);

    localparam logic [kmp_pkg::POSITION_BITS-1:0] POS_MAX = '1;

    // Configuration storage
    logic [kmp_pkg::LEN_BITS-1:0]  len_reg;
    logic [kmp_pkg::BYTE_BITS-1:0] pat_reg [kmp_pkg::PATTERN_MAX];

    // Search state and output register
    logic [kmp_pkg::POSITION_BITS-1:0] pos_reg, pos_next;
    logic                              out_valid_reg, out_valid_next;
    logic                              out_found_reg, out_found_next;
    logic [kmp_pkg::START_BITS-1:0]    out_start_reg, out_start_next;

    logic                              in_acc;
    logic                              cfg_hit;
    kmp_pkg::cell_ctrl_t               ctrl;
    logic [kmp_pkg::PATTERN_MAX-1:0]   chain_in_vec;
    logic [kmp_pkg::PATTERN_MAX-1:0]   chain_out_vec;
    logic [kmp_pkg::PATTERN_MAX-1:0]   hit_vec;
    logic [kmp_pkg::EFF_BITS-1:0]      n_eff;
    logic [kmp_pkg::IDX_BITS-1:0]      last_idx;
    logic                              match_now;
    logic [kmp_pkg::POSITION_BITS-1:0] start_pos;

    // Take a byte whenever the output register is free or drains this cycle
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // Only writes to a listed register restart the search
    assign cfg_hit = cfg_we && (cfg_index <= kmp_pkg::REG_BYTES_3);

    always_comb
    begin
        ctrl.advance = in_acc;
        ctrl.clear   = cfg_hit || (in_acc && s_axis_tlast);
    end

    // Pattern length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            len_reg <= kmp_pkg::LEN_BITS'(1);
        else if (cfg_we && cfg_index == kmp_pkg::REG_LENGTH)
            len_reg <= cfg_data[kmp_pkg::LEN_BITS-1:0];
    end

    // Pattern bytes and the row of cells, one per pattern byte
    genvar k;
    generate
        for (k = 0; k < kmp_pkg::PATTERN_MAX; k++)
        begin : g_cell
            localparam int WORD = k / kmp_pkg::BYTES_PER_REG;
            localparam int LANE = k % kmp_pkg::BYTES_PER_REG;

            if (WORD < kmp_pkg::NUM_WORDS)
            begin : g_store
                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                        pat_reg[k] <= '0;
                    else if (cfg_we && cfg_index ==
                             kmp_pkg::CFG_IDX_BITS'(int'(kmp_pkg::REG_BYTES_0) + WORD))
                        pat_reg[k] <= cfg_data[LANE*kmp_pkg::BYTE_BITS +: kmp_pkg::BYTE_BITS];
                end
            end
            else
            begin : g_zero
                // Bytes past the programmable range read as zero
                assign pat_reg[k] = '0;
            end

            if (k == 0)
            begin : g_head
                // The empty prefix always matches
                assign chain_in_vec[k] = 1'b1;
            end
            else
            begin : g_link
                assign chain_in_vec[k] = chain_out_vec[k-1];
            end

            kmp_cell u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctrl         (ctrl),
                .pattern_byte (pat_reg[k]),
                .text_byte    (s_axis_tdata),
                .chain_in     (chain_in_vec[k]),
                .hit          (hit_vec[k]),
                .chain_out    (chain_out_vec[k])
            );
        end
    endgenerate

    // A full occurrence ends here when the cell of the last pattern byte hits
    assign n_eff     = kmp_pkg::eff_len(len_reg);
    assign last_idx  = kmp_pkg::IDX_BITS'(n_eff - kmp_pkg::EFF_BITS'(1));
    assign match_now = hit_vec[last_idx];
    assign start_pos = pos_reg - kmp_pkg::POSITION_BITS'(last_idx);

    always_comb
    begin
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        out_start_next = out_start_reg;

        if (m_axis_tready)
            out_valid_next = 1'b0;

        if (in_acc)
        begin
            out_valid_next = 1'b1;
            out_found_next = match_now;
            out_start_next = match_now ? kmp_pkg::START_BITS'(start_pos) : '0;
            // Advance the position, hold at saturation
            if (pos_reg != POS_MAX)
                pos_next = pos_reg + kmp_pkg::POSITION_BITS'(1);
        end

        if (ctrl.clear)
            pos_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_found_reg <= 1'b0;
            out_start_reg <= '0;
        end
        else
        begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            out_found_reg <= out_found_next;
            out_start_reg <= out_start_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_found_reg;
    assign m_axis_tdata  = out_start_reg;

    // End of text returns the position to zero
    `ASSERT_NEXT(a_eot_clears_pos, in_acc && s_axis_tlast, pos_reg == '0)
    // A saturated position stays saturated while the text continues
    `ASSERT_NEXT(a_pos_saturates, in_acc && !s_axis_tlast && !cfg_hit && pos_reg == POS_MAX,
                 pos_reg == POS_MAX)
    // A result without a match reports a zero start
    `ASSERT_NOW(a_nomatch_zero, out_valid_reg && !out_found_reg, out_start_reg == '0)
    // Every byte taken leaves a result behind
    `ASSERT_NEXT(a_acc_gives_result, in_acc, out_valid_reg)

endmodule

@@ src/kmp_cell.sv @@
// One cell of the matcher chain: holds one prefix flag and compares one pattern byte.
module kmp_cell (
    input  logic                               clk,
    input  logic                               rst_n,
    input  kmp_pkg::cell_ctrl_t                ctrl,
    input  logic [kmp_pkg::BYTE_BITS-1:0]      pattern_byte,
    input  logic [kmp_pkg::BYTE_BITS-1:0]      text_byte,
    input  logic                               chain_in,
    output logic                               hit,
    output logic                               chain_out
);

    logic hit_reg;
    logic hit_next;

    // Extend the prefix held by the left neighbor when this byte matches
    assign hit = chain_in && (pattern_byte == text_byte);

    always_comb
    begin
        hit_next = hit_reg;
        if (ctrl.clear)
            hit_next = 1'b0;
        else if (ctrl.advance)
            hit_next = hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hit_reg <= 1'b0;
        else
            hit_reg <= hit_next;
    end

    assign chain_out = hit_reg;

endmodule

@@ tb/kmp_stream_matcher_test.sv @@
// Self-checking testbench of the streaming KMP pattern matcher.
module kmp_stream_matcher_test;

    // Bound on the whole run: every byte paying the longest sender gap and
    // the longest receiver stall, plus all register writes, several times over.
    localparam int unsigned RUN_LIMIT    = 2_000_000;
    localparam int unsigned RANDOM_ITEMS = 1350;
    localparam int unsigned CFG_INDEXES  = 2 ** kmp_pkg::CFG_IDX_BITS;

    // One result request as the matcher should send it
    typedef struct packed {
        logic                           found;
        logic [kmp_pkg::START_BITS-1:0] start;
    } match_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                             cfg_we = 1'b0;
    logic [kmp_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [kmp_pkg::CFG_BITS-1:0]     cfg_data = '0;

    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [7:0]              s_axis_tdata = '0;   // [7:0] text_byte
    logic                    s_axis_tlast = 1'b0; // end_of_text

    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [31:0]             m_axis_tdata;        // [31:0] match_start
    logic                    m_axis_tuser;        // [0] match_found

    // Shadow copy of the matcher: programmed registers, failure table,
    // matched prefix length and byte position
    logic [kmp_pkg::LEN_BITS-1:0]      shadow_len = kmp_pkg::LEN_BITS'(1);
    logic [kmp_pkg::CFG_BITS-1:0]      shadow_words [kmp_pkg::NUM_WORDS];
    logic [kmp_pkg::LEN_BITS-1:0]      shadow_fail [kmp_pkg::PATTERN_MAX];
    logic [kmp_pkg::LEN_BITS-1:0]      shadow_prefix = '0;
    logic [kmp_pkg::POSITION_BITS-1:0] shadow_pos = '0;

    match_result_t expected_matches [$];

    // Sender and receiver idling controls, set per phase
    int unsigned tx_gap_pct = 0;
    int unsigned tx_burst_left = 0;
    int unsigned rx_stall_pct = 0;
    int unsigned rx_run_left = 0;
    logic        rx_ready_state = 1'b1;

    int unsigned mismatches = 0;
    int unsigned text_bytes_sent = 0;
    int unsigned matches_expected = 0;
    int unsigned reg_writes = 0;
    int unsigned text_ends = 0;

    kmp_stream_matcher i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow matcher
    // ------------------------------------------------------------------

    // Length in use: zero acts as one, anything past the row acts as full
    function automatic int unsigned used_length();
        int unsigned n;
        n = int'(shadow_len);
        if (n < 1)
            n = 1;
        if (n > kmp_pkg::PATTERN_MAX)
            n = kmp_pkg::PATTERN_MAX;
        return n;
    endfunction

    function automatic logic [7:0] pattern_byte(int unsigned k);
        if (k >= kmp_pkg::PATTERN_MAX)
            return 8'h00;
        return shadow_words[k / kmp_pkg::BYTES_PER_REG][(k % kmp_pkg::BYTES_PER_REG) * 8 +: 8];
    endfunction

    // Classic prefix function over the bytes in use; entries past the
    // length are zero
    function automatic void rebuild_failure_table();
        int unsigned n;
        int unsigned k;
        n = used_length();
        k = 0;
        shadow_fail[0] = '0;
        for (int unsigned i = 1; i < kmp_pkg::PATTERN_MAX; i++) begin
            if (i < n) begin
                while (k > 0 && pattern_byte(k) != pattern_byte(i))
                    k = shadow_fail[k - 1];
                if (pattern_byte(k) == pattern_byte(i))
                    k++;
                shadow_fail[i] = kmp_pkg::LEN_BITS'(k);
            end
            else begin
                shadow_fail[i] = '0;
            end
        end
    endfunction

    // Advance the shadow state by one text byte and return the result
    // that byte should produce
    function automatic match_result_t predict_match(logic [7:0] text_byte, logic end_mark);
        match_result_t r;
        int unsigned   n;
        int unsigned   q;
        r = '0;
        n = used_length();
        q = shadow_prefix;
        if (q >= n)
            q = 0;
        while (q > 0 && pattern_byte(q) != text_byte)
            q = shadow_fail[q - 1];
        if (pattern_byte(q) == text_byte)
            q++;
        if (q == n) begin
            // full occurrence: report it and fall back so overlaps are found
            r.found = 1'b1;
            r.start = kmp_pkg::START_BITS'(shadow_pos - kmp_pkg::POSITION_BITS'(n - 1));
            q = shadow_fail[n - 1];
        end
        if (shadow_pos != '1)
            shadow_pos++;
        if (end_mark) begin
            q = 0;
            shadow_pos = '0;
        end
        shadow_prefix = kmp_pkg::LEN_BITS'(q);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // Write one register; the matcher must be idle. Indexes past the last
    // pattern word are dropped by the block and leave the search running.
    task automatic write_reg(logic [kmp_pkg::CFG_IDX_BITS-1:0] idx,
                             logic [kmp_pkg::CFG_BITS-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        reg_writes++;
        if (idx == kmp_pkg::REG_LENGTH)
            shadow_len = value[kmp_pkg::LEN_BITS-1:0];
        else if (idx <= kmp_pkg::REG_BYTES_3)
            shadow_words[idx - kmp_pkg::REG_BYTES_0] = value;
        if (idx <= kmp_pkg::REG_BYTES_3) begin
            rebuild_failure_table();
            shadow_prefix = '0;
            shadow_pos    = '0;
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Drop tvalid and hold until every outstanding result has come back
    task automatic wait_results_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_matches.size() != 0)
            @(posedge clk);
    endtask

    // Offer one text byte, hold it until the request is taken, then record
    // the result it should produce. Bytes come in random-length bursts, some opened by a gap.
    task automatic send_byte(logic [7:0] text_byte, logic end_mark);
        int unsigned gap;
        gap = 0;
        if (tx_burst_left == 0) begin
            tx_burst_left = $urandom_range(1, 16);
            if ($urandom_range(99) < tx_gap_pct)
                gap = $urandom_range(1, 5);
        end
        tx_burst_left--;
        if (gap != 0) begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1)
                @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= text_byte;
        s_axis_tlast  <= end_mark;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_matches.push_back(predict_match(text_byte, end_mark));
        text_bytes_sent++;
        if (expected_matches[$].found)
            matches_expected++;
        if (end_mark)
            text_ends++;
    endtask

    task automatic send_text(string s, bit end_mark);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], end_mark && (i == s.len() - 1));
    endtask

    // Program length and all four pattern words, byte k at bits 8k upward
    task automatic program_pattern(logic [kmp_pkg::CFG_BITS-1:0] len_value,
                                   logic [kmp_pkg::NUM_WORDS*kmp_pkg::CFG_BITS-1:0] packed_bytes);
        wait_results_drained();
        write_reg(kmp_pkg::REG_LENGTH, len_value);
        for (int w = 0; w < kmp_pkg::NUM_WORDS; w++)
            write_reg(kmp_pkg::CFG_IDX_BITS'(int'(kmp_pkg::REG_BYTES_0) + w),
                      packed_bytes[w * kmp_pkg::CFG_BITS +: kmp_pkg::CFG_BITS]);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset leaves a one-byte zero pattern in place
    task automatic test_reset_pattern();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    // "aba" against "ababa": the second occurrence shares a byte with the first
    task automatic test_overlapping_matches();
        program_pattern(64'd3, 256'h616261);
        send_text("ababa", 1'b1);
    endtask

    // A partial match must not carry across an end-of-text mark
    task automatic test_end_of_text();
        send_text("ab", 1'b1);
        send_text("aba", 1'b1);
    endtask

    // Length zero acts as one; upper data bits of the length write are dropped
    task automatic test_length_clamp();
        program_pattern(64'hFFFF_FFFF_FFFF_FFC0, 256'hFF);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    // Writes to unused indexes must leave a partial match intact
    task automatic test_ignored_index();
        program_pattern(64'd3, 256'h636261);
        send_text("ab", 1'b0);
        wait_results_drained();
        for (int unsigned u = kmp_pkg::REG_BYTES_3 + 1; u < CFG_INDEXES; u++)
            write_reg(kmp_pkg::CFG_IDX_BITS'(u), {$urandom, $urandom});
        send_text("c", 1'b1);
    endtask

    // Phases of random configuration and mostly well-formed text built from
    // the pattern, with noise bytes and random end-of-text marks mixed in
    task automatic test_random_phases();
        logic [7:0]                   alpha [4];
        logic [7:0]                   pat_gen [kmp_pkg::PATTERN_MAX];
        logic [kmp_pkg::CFG_BITS-1:0] word;
        int unsigned                  order [5];
        int unsigned                  alpha_size;
        int unsigned                  len_value;
        int unsigned                  phase;
        int unsigned                  rand_items;
        int unsigned                  target;
        int unsigned                  sent;
        int unsigned                  n;
        int unsigned                  choice;
        int unsigned                  span;
        int unsigned                  tmp;
        int unsigned                  j;
        int                           pause_at;
        bit                           noise;
        phase = 0;
        rand_items = 0;
        while (rand_items < RANDOM_ITEMS) begin
            // pick the length: the row's extremes first, then mostly short ones
            choice = $urandom_range(99);
            if (phase == 0)
                len_value = kmp_pkg::PATTERN_MAX;
            else if (phase == 1)
                len_value = 63;
            else if (phase == 2)
                len_value = 0;
            else if (choice < 60)
                len_value = $urandom_range(1, 6);
            else if (choice < 75)
                len_value = $urandom_range(7, kmp_pkg::PATTERN_MAX - 1);
            else if (choice < 85)
                len_value = kmp_pkg::PATTERN_MAX;
            else if (choice < 93)
                len_value = $urandom_range(kmp_pkg::PATTERN_MAX + 1, 63);
            else
                len_value = 0;

            alpha_size = $urandom_range(1, 4);
            foreach (alpha[a])
                alpha[a] = 8'($urandom_range(0, 255));
            noise = ($urandom_range(99) < 15);
            n = (len_value == 0) ? 1 :
                ((len_value > kmp_pkg::PATTERN_MAX) ? kmp_pkg::PATTERN_MAX : len_value);
            foreach (pat_gen[k])
                pat_gen[k] = (noise || k >= n) ? 8'($urandom_range(0, 255))
                                               : alpha[$urandom_range(0, alpha_size - 1)];

            // write the registers in random order; later phases may skip words
            foreach (order[k])
                order[k] = k;
            for (int k = 4; k > 0; k--) begin
                j = $urandom_range(0, k);
                tmp = order[k];
                order[k] = order[j];
                order[j] = tmp;
            end
            wait_results_drained();
            foreach (order[k]) begin
                if (order[k] == kmp_pkg::REG_LENGTH) begin
                    word = {$urandom, $urandom};
                    word[kmp_pkg::LEN_BITS-1:0] = kmp_pkg::LEN_BITS'(len_value);
                    write_reg(kmp_pkg::REG_LENGTH, word);
                end
                else if (phase < 3 || $urandom_range(99) < 80) begin
                    for (int b = 0; b < kmp_pkg::BYTES_PER_REG; b++)
                        word[b * 8 +: 8] =
                            pat_gen[(order[k] - kmp_pkg::REG_BYTES_0) * kmp_pkg::BYTES_PER_REG + b];
                    write_reg(kmp_pkg::CFG_IDX_BITS'(order[k]), word);
                end
            end
            if ($urandom_range(99) < 30)
                write_reg(kmp_pkg::CFG_IDX_BITS'($urandom_range(kmp_pkg::REG_BYTES_3 + 1,
                                                                CFG_INDEXES - 1)),
                          {$urandom, $urandom});

            // idling for this phase; some phases run back to back
            tx_gap_pct   = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 80);
            rx_stall_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 70);

            n = used_length();
            target = $urandom_range(40, 100);
            pause_at = ($urandom_range(99) < 30) ? $urandom_range(1, target) : -1;
            sent = 0;
            while (sent < target) begin
                choice = $urandom_range(99);
                if (choice < 45)
                    span = n;
                else if (choice < 65)
                    span = $urandom_range(1, n);
                else
                    span = 1;
                for (int unsigned k = 0; k < span; k++) begin
                    if (choice < 65)
                        tmp = pattern_byte(k);
                    else if (choice < 90)
                        tmp = pattern_byte($urandom_range(0, n - 1));
                    else
                        tmp = $urandom_range(0, 255);
                    send_byte(8'(tmp), $urandom_range(59) == 0);
                    sent++;
                    // hold off until the result stream has caught up
                    if (int'(sent) == pause_at)
                        wait_results_drained();
                end
            end
            rand_items += sent;
            phase++;
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: ready and stall runs of random length, independent of the sender
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (rx_run_left == 0) begin
            rx_ready_state = ($urandom_range(99) >= rx_stall_pct);
            rx_run_left    = rx_ready_state ? $urandom_range(1, 12) : $urandom_range(1, 6);
        end
        rx_run_left--;
        m_axis_tready <= rx_ready_state;
    end

    // Compare every taken result request with the oldest expectation
    always @(posedge clk) begin : result_checker
        match_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_matches.size() == 0) begin
                report_mismatch($sformatf("result with none pending: tuser=%0b tdata=%h",
                                          m_axis_tuser, m_axis_tdata));
            end
            else begin
                want = expected_matches.pop_front();
                if (m_axis_tuser !== want.found)
                    report_mismatch($sformatf("match flag %0b, want %0b",
                                              m_axis_tuser, want.found));
                if (m_axis_tdata !== want.start)
                    report_mismatch($sformatf("match start %h, want %h",
                                              m_axis_tdata, want.start));
            end
        end
    end

    initial begin
        #(RUN_LIMIT);
        $display("run limit reached with %0d results pending", expected_matches.size());
        $display("FAIL");
        $finish;
    end

    initial begin
        foreach (shadow_words[w])
            shadow_words[w] = '0;
        rebuild_failure_table();
        repeat (8)
            @(negedge clk);
        rst_n <= 1'b1;

        // directed part runs without idling
        test_reset_pattern();
        test_overlapping_matches();
        test_end_of_text();
        test_length_clamp();
        test_ignored_index();
        test_random_phases();

        // let the last results arrive, then a few quiet cycles
        wait_results_drained();
        repeat (8)
            @(posedge clk);
        $display("sent %0d text bytes with %0d end marks, %0d occurrences expected",
                 text_bytes_sent, text_ends, matches_expected);
        $display("%0d register writes across pattern lengths 0 to 63, %0d mismatches",
                 reg_writes, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
